// ===== hdl/seeded_hash64_stream_defines.svh =====
// Assertion macros used by the checker file of the seeded hash block.
`ifndef SEEDED_HASH64_STREAM_DEFINES_SVH
`define SEEDED_HASH64_STREAM_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define SH64_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seeded hash check failed one cycle after its condition");

// The consequent must hold in the same cycle as the antecedent.
`define SH64_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seeded hash check failed in the cycle of its condition");

`endif

// ===== hdl/sh64_pkg.sv =====
// Package with the constants, types and helper functions of the seeded hash block.
package sh64_pkg;

    localparam int LENGTH_BITS  = 32;
    localparam int LEN_PORT_BITS = 32;
    localparam int LEN_USE_BITS = (LENGTH_BITS < LEN_PORT_BITS) ? LENGTH_BITS : LEN_PORT_BITS;

    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] CHUNK_K = 64'h87C37B91114253D5;
    localparam logic [63:0] ADD_K = 64'h0000000052DCE729;
    localparam logic [63:0] FIN_K1 = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] FIN_K2 = 64'hC4CEB9FE1A85EC53;

    localparam int CHUNK_ROT = 31;
    localparam int ACC_ROT = 27;
    localparam int FIN_SHIFT = 33;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CHUNK_EMPTY,
        CHUNK_TAIL,
        CHUNK_FULL
    } chunk_kind_t;

    typedef struct packed {
        logic [63:0] init;
        logic        use_init;
        logic [63:0] key;
        chunk_kind_t kind;
        logic        emit;
    } cmd_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_LEN_GO,
        F_LEN_WAIT,
        F_KEY_GO,
        F_KEY_WAIT,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ADD,
        B_FIN1_GO,
        B_FIN1_WAIT,
        B_FIN2_GO,
        B_FIN2_WAIT,
        B_OUT
    } back_state_t;

    function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [63:0] fold33(input logic [63:0] v);
        return v ^ (v >> FIN_SHIFT);
    endfunction

endpackage

// ===== hdl/sh64_mul.sv =====
// Iterative 64 by 64 bit multiplier giving the low 64 bits from three 32 by 32 bit products.
module sh64_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output logic        done,
    output logic [63:0] product
);

    logic        busy_reg;
    logic [1:0]  phase_reg;
    logic        done_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] prod_reg;
    logic [63:0] sum_reg;
    logic [31:0] op_x;
    logic [31:0] op_y;
    logic [63:0] addend;

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[31:0];
            end
            2'd1:
            begin
                op_x = a_reg[31:0];
                op_y = b_reg[63:32];
            end
            default:
            begin
                op_x = a_reg[63:32];
                op_y = b_reg[31:0];
            end
        endcase
        addend = (phase_reg == 2'd1) ? prod_reg : {prod_reg[31:0], 32'h0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (phase_reg == 2'd3);
            if (start && !busy_reg)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            a_reg   <= a;
            b_reg   <= b;
            sum_reg <= 64'h0;
        end
        else if (busy_reg)
        begin
            prod_reg <= 64'(op_x) * 64'(op_y);
            if (phase_reg != 2'd0)
            begin
                sum_reg <= sum_reg + addend;
            end
        end
    end

    assign done    = done_reg;
    assign product = sum_reg;

endmodule

// ===== hdl/sh64_queue.sv =====
// Short command queue between the front and back parts of the seeded hash block.
module sh64_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  sh64_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output sh64_pkg::cmd_t pop_cmd
);

    localparam int PtrBits = (sh64_pkg::QUEUE_DEPTH > 1) ? $clog2(sh64_pkg::QUEUE_DEPTH) : 1;
    localparam int CntBits = $clog2(sh64_pkg::QUEUE_DEPTH + 1);
    localparam logic [CntBits-1:0] FullCount = CntBits'(sh64_pkg::QUEUE_DEPTH);
    localparam logic [PtrBits-1:0] LastPtr = PtrBits'(sh64_pkg::QUEUE_DEPTH - 1);

    sh64_pkg::cmd_t       entry_reg [sh64_pkg::QUEUE_DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [CntBits-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != FullCount);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/sh64_front.sv =====
// Front part: accepts input beats, classifies chunks and precomputes the seed and chunk mix terms.
module sh64_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [63:0]    seed,
    input  logic [31:0]    message_length,
    input  logic [63:0]    chunk_data,
    input  logic [3:0]     chunk_bytes,
    input  logic           first_chunk,
    input  logic           last_chunk,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           push_valid,
    input  logic           push_ready,
    output sh64_pkg::cmd_t push_cmd
);

    sh64_pkg::front_state_t state_reg;
    sh64_pkg::front_state_t state_next;

    logic [63:0]           seed_reg;
    logic [63:0]           len_reg;
    logic [63:0]           data_reg;
    sh64_pkg::chunk_kind_t kind_reg;
    logic                  first_reg;
    logic                  emit_reg;
    logic [63:0]           init_reg;
    logic [63:0]           init_next;
    logic [63:0]           key_reg;
    logic [63:0]           key_next;

    logic [3:0]            count_clamped;
    logic [63:0]           data_masked;
    sh64_pkg::chunk_kind_t kind_in;
    logic                  accept;

    logic                  mul_start;
    logic [63:0]           mul_a;
    logic [63:0]           mul_b;
    logic                  mul_done;
    logic [63:0]           mul_product;

    sh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign accept = in_valid && in_ready;

    always_comb
    begin
        count_clamped = (chunk_bytes > 4'd8) ? 4'd8 : chunk_bytes;
        for (int i = 0; i < 8; i++)
        begin
            data_masked[8*i +: 8] = (4'(i) < count_clamped) ? chunk_data[8*i +: 8] : 8'h00;
        end
        if (count_clamped == 4'd0)
        begin
            kind_in = sh64_pkg::CHUNK_EMPTY;
        end
        else if (count_clamped == 4'd8)
        begin
            kind_in = sh64_pkg::CHUNK_FULL;
        end
        else
        begin
            kind_in = sh64_pkg::CHUNK_TAIL;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sh64_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    if (first_chunk)
                    begin
                        state_next = sh64_pkg::F_LEN_GO;
                    end
                    else if (kind_in != sh64_pkg::CHUNK_EMPTY)
                    begin
                        state_next = sh64_pkg::F_KEY_GO;
                    end
                    else
                    begin
                        state_next = sh64_pkg::F_PUSH;
                    end
                end
            end
            sh64_pkg::F_LEN_GO:
            begin
                state_next = sh64_pkg::F_LEN_WAIT;
            end
            sh64_pkg::F_LEN_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = (kind_reg != sh64_pkg::CHUNK_EMPTY) ? sh64_pkg::F_KEY_GO
                                                                     : sh64_pkg::F_PUSH;
                end
            end
            sh64_pkg::F_KEY_GO:
            begin
                state_next = sh64_pkg::F_KEY_WAIT;
            end
            sh64_pkg::F_KEY_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = sh64_pkg::F_PUSH;
                end
            end
            sh64_pkg::F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = sh64_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = sh64_pkg::F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        push_valid = 1'b0;
        mul_start  = 1'b0;
        mul_a      = len_reg;
        mul_b      = sh64_pkg::GOLDEN;
        init_next  = init_reg;
        key_next   = key_reg;
        unique case (state_reg)
            sh64_pkg::F_IDLE:
            begin
                in_ready = 1'b1;
            end
            sh64_pkg::F_LEN_GO:
            begin
                mul_start = 1'b1;
            end
            sh64_pkg::F_LEN_WAIT:
            begin
                if (mul_done)
                begin
                    init_next = seed_reg ^ mul_product;
                end
            end
            sh64_pkg::F_KEY_GO:
            begin
                mul_start = 1'b1;
                mul_a     = data_reg;
                mul_b     = sh64_pkg::CHUNK_K;
            end
            sh64_pkg::F_KEY_WAIT:
            begin
                if (mul_done)
                begin
                    key_next = sh64_pkg::rotl64(mul_product, sh64_pkg::CHUNK_ROT);
                end
            end
            sh64_pkg::F_PUSH:
            begin
                push_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign push_cmd = '{init: init_reg, use_init: first_reg, key: key_reg,
                        kind: kind_reg, emit: emit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sh64_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        init_reg <= init_next;
        key_reg  <= key_next;
        if (accept)
        begin
            seed_reg  <= seed;
            len_reg   <= 64'(message_length[sh64_pkg::LEN_USE_BITS-1:0]);
            data_reg  <= data_masked;
            kind_reg  <= kind_in;
            first_reg <= first_chunk;
            emit_reg  <= (kind_in != sh64_pkg::CHUNK_FULL) || last_chunk;
        end
    end

endmodule

// ===== hdl/sh64_back.sv =====
// Back part: keeps the accumulator, applies chunk commands and finalises the hash.
module sh64_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  sh64_pkg::cmd_t pop_cmd,
    output logic [63:0]    hash_value,
    output logic           out_valid,
    input  logic           out_ready
);

    sh64_pkg::back_state_t state_reg;
    sh64_pkg::back_state_t state_next;

    logic [63:0] acc_reg;
    logic [63:0] acc_next;
    logic [63:0] tmp_reg;
    logic [63:0] tmp_next;
    logic [63:0] h_reg;
    logic [63:0] h_next;
    logic        emit_reg;
    logic        emit_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;

    logic [63:0] base;
    logic [63:0] mixed;
    logic [63:0] rotated;
    logic        out_free;

    logic        mul_start;
    logic [63:0] mul_a;
    logic [63:0] mul_b;
    logic        mul_done;
    logic [63:0] mul_product;

    sh64_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        base    = pop_cmd.use_init ? pop_cmd.init : acc_reg;
        mixed   = (pop_cmd.kind != sh64_pkg::CHUNK_EMPTY) ? (base ^ pop_cmd.key) : base;
        rotated = sh64_pkg::rotl64(mixed, sh64_pkg::ACC_ROT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sh64_pkg::B_IDLE:
            begin
                if (pop_valid)
                begin
                    if (pop_cmd.kind == sh64_pkg::CHUNK_FULL)
                    begin
                        state_next = sh64_pkg::B_ADD;
                    end
                    else if (pop_cmd.emit)
                    begin
                        state_next = sh64_pkg::B_FIN1_GO;
                    end
                end
            end
            sh64_pkg::B_ADD:
            begin
                state_next = emit_reg ? sh64_pkg::B_FIN1_GO : sh64_pkg::B_IDLE;
            end
            sh64_pkg::B_FIN1_GO:
            begin
                state_next = sh64_pkg::B_FIN1_WAIT;
            end
            sh64_pkg::B_FIN1_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = sh64_pkg::B_FIN2_GO;
                end
            end
            sh64_pkg::B_FIN2_GO:
            begin
                state_next = sh64_pkg::B_FIN2_WAIT;
            end
            sh64_pkg::B_FIN2_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = sh64_pkg::B_OUT;
                end
            end
            sh64_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    state_next = sh64_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = sh64_pkg::B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop_ready      = 1'b0;
        mul_start      = 1'b0;
        mul_a          = sh64_pkg::fold33(acc_reg);
        mul_b          = sh64_pkg::FIN_K1;
        acc_next       = acc_reg;
        tmp_next       = tmp_reg;
        h_next         = h_reg;
        emit_next      = emit_reg;
        hash_next      = hash_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            sh64_pkg::B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    acc_next  = mixed;
                    tmp_next  = (rotated << 2) + rotated;
                    emit_next = pop_cmd.emit;
                end
            end
            sh64_pkg::B_ADD:
            begin
                acc_next = tmp_reg + sh64_pkg::ADD_K;
            end
            sh64_pkg::B_FIN1_GO:
            begin
                mul_start = 1'b1;
            end
            sh64_pkg::B_FIN1_WAIT:
            begin
                if (mul_done)
                begin
                    h_next = sh64_pkg::fold33(mul_product);
                end
            end
            sh64_pkg::B_FIN2_GO:
            begin
                mul_start = 1'b1;
                mul_a     = h_reg;
                mul_b     = sh64_pkg::FIN_K2;
            end
            sh64_pkg::B_FIN2_WAIT:
            begin
                if (mul_done)
                begin
                    h_next = sh64_pkg::fold33(mul_product);
                end
            end
            sh64_pkg::B_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    hash_next      = h_reg;
                end
            end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sh64_pkg::B_IDLE;
            acc_reg       <= 64'h0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tmp_reg  <= tmp_next;
        h_reg    <= h_next;
        emit_reg <= emit_next;
        hash_reg <= hash_next;
    end

    assign hash_value = hash_reg;
    assign out_valid  = out_valid_reg;

endmodule

// ===== hdl/seeded_hash64_stream.sv =====
// Top level of the seeded 64-bit streaming hash with its front, queue and back parts.
//
// Input beats carry one message chunk each (seed, message_length, chunk_data, chunk_bytes,
// first_chunk, last_chunk) over in_valid/in_ready. A chunk with first_chunk set starts a
// new message from the seed and length; a chunk of fewer than eight bytes or with
// last_chunk set ends it, and one beat of hash_value then leaves over out_valid/out_ready.
// The front takes a beat and precomputes the seed and chunk terms on its own iterative
// multiplier, the seed term only for a first chunk and the chunk term only for a chunk
// that is not empty, and then waits for room in the queue before it takes the next beat.
// That multiplier, one 32 by 32 bit product per cycle, sets the steady rate of full
// chunks. A two-entry queue lets the front run ahead of the back. The back applies a tail
// or empty chunk in its idle state and a full chunk there and in an add step, then runs
// the two finalising multiplications before it offers a hash.
// The result waits in an output register; while the receiver stalls,
// the back keeps applying chunks and halts only when it has a further hash to deliver,
// after which the queue and then in_ready fill up. Reset clears the accumulator to zero,
// empties the queue and drops out_valid.
module seeded_hash64_stream (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] seed,
    input  logic [31:0] message_length,
    input  logic [63:0] chunk_data,
    input  logic [3:0]  chunk_bytes,
    input  logic        first_chunk,
    input  logic        last_chunk,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [63:0] hash_value,
    output logic        out_valid,
    input  logic        out_ready
);

    logic           push_valid;
    logic           push_ready;
    sh64_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    sh64_pkg::cmd_t pop_cmd;

    sh64_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed           (seed),
        .message_length (message_length),
        .chunk_data     (chunk_data),
        .chunk_bytes    (chunk_bytes),
        .first_chunk    (first_chunk),
        .last_chunk     (last_chunk),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_cmd       (push_cmd)
    );

    sh64_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    sh64_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd),
        .hash_value (hash_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready)
    );

endmodule

// ===== hdl/sh64_checker.sv =====
// Port-level checker for the seeded hash block, bound to its top level.
`include "seeded_hash64_stream_defines.svh"

module sh64_checker (
    input logic        clk,
    input logic        rst_n,
    input logic [3:0]  chunk_bytes,
    input logic        last_chunk,
    input logic        in_valid,
    input logic        in_ready,
    input logic [63:0] hash_value,
    input logic        out_valid,
    input logic        out_ready
);

    logic [2:0] pending_reg;
    logic [2:0] pending_next;
    logic       in_emit_beat;
    logic       out_beat;

    assign in_emit_beat = in_valid && in_ready && ((chunk_bytes < 4'd8) || last_chunk);
    assign out_beat     = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_emit_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_beat && !in_emit_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 3'd0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A hash waiting to be taken stays offered and unchanged.
    `SH64_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `SH64_ASSERT_NEXT(a_hash_hold, clk, rst_n, out_valid && !out_ready, $stable(hash_value))
    // Every hash beat belongs to a message end that was accepted earlier.
    `SH64_ASSERT_NOW(a_no_extra, clk, rst_n, out_valid, pending_reg != 3'd0)
    // Front, queue, back and output register together hold at most five message ends.
    `SH64_ASSERT_NOW(a_bounded, clk, rst_n, 1'b1, pending_reg <= 3'd5)

endmodule

bind seeded_hash64_stream sh64_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .chunk_bytes (chunk_bytes),
    .last_chunk  (last_chunk),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .hash_value  (hash_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready)
);

// ===== verif/testbench.sv =====
// Self-checking testbench for the seeded 64-bit streaming hash block, with its own hash predictor.
module testbench;

    localparam logic [63:0] LENGTH_SCALE = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] LANE_MULT = 64'h87C37B91114253D5;
    localparam logic [63:0] STEP_ADD = 64'h0000000052DCE729;
    localparam logic [63:0] AVAL_MULT_A = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] AVAL_MULT_B = 64'hC4CEB9FE1A85EC53;
    localparam logic [3:0] FULL_LANE = 4'd8;
    localparam int unsigned STIMULUS_ITEMS = 1750;
    localparam int unsigned DRAIN_CYCLES = 100;
    localparam int unsigned CYCLE_LIMIT = 600000;

    typedef enum int unsigned {
        END_TAIL,
        END_EMPTY,
        END_LAST
    } msg_end_t;

    typedef struct {
        logic [63:0] seed;
        logic [31:0] length;
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        opens;
        logic        ends;
        int unsigned gap;
    } chunk_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [63:0] seed = 64'd0;
    logic [31:0] message_length = 32'd0;
    logic [63:0] chunk_data = 64'd0;
    logic [3:0]  chunk_bytes = 4'd0;
    logic        first_chunk = 1'b0;
    logic        last_chunk = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [63:0] hash_value;
    logic        out_valid;
    logic        out_ready = 1'b0;

    chunk_item_t pending_chunks[$];
    chunk_item_t on_bus;
    logic [63:0] expected_hashes[$];
    logic [63:0] running_hash = 64'd0;
    logic [63:0] fresh_digest;
    logic [63:0] wanted_hash;
    int unsigned queued_total = 0;
    int unsigned hashes_seen = 0;
    int unsigned hold_off = 0;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int unsigned cycle_count = 0;
    int unsigned error_count = 0;

    seeded_hash64_stream i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .seed           (seed),
        .message_length (message_length),
        .chunk_data     (chunk_data),
        .chunk_bytes    (chunk_bytes),
        .first_chunk    (first_chunk),
        .last_chunk     (last_chunk),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hash_value     (hash_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [63:0] avalanche(input logic [63:0] v);
        logic [63:0] h;
        h = v ^ (v >> 33);
        h = h * AVAL_MULT_A;
        h = h ^ (h >> 33);
        h = h * AVAL_MULT_B;
        return h ^ (h >> 33);
    endfunction

    // Updates the running hash with one chunk and tells whether the message ends here.
    function automatic bit absorb_chunk(input chunk_item_t c, output logic [63:0] digest);
        logic [3:0]  count;
        logic [63:0] lane;
        logic [63:0] product;
        count = (c.nbytes > FULL_LANE) ? FULL_LANE : c.nbytes;
        if (c.opens)
        begin
            running_hash = c.seed ^ ({32'd0, c.length} * LENGTH_SCALE);
        end
        if (count != 4'd0)
        begin
            if (count == FULL_LANE)
            begin
                lane = c.data;
            end
            else
            begin
                lane = c.data & ((64'd1 << {count, 3'b000}) - 64'd1);
            end
            product = lane * LANE_MULT;
            running_hash = running_hash ^ {product[32:0], product[63:33]};
            if (count == FULL_LANE)
            begin
                running_hash = {running_hash[36:0], running_hash[63:37]} * 64'd5 + STEP_ADD;
            end
        end
        digest = avalanche(running_hash);
        return (count < FULL_LANE) || c.ends;
    endfunction

    function automatic logic [63:0] random64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [3:0] full_count_code();
        if ($urandom_range(0, 7) == 0)
        begin
            return 4'($urandom_range(9, 15));
        end
        return FULL_LANE;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    task automatic queue_chunk(input logic [63:0] s, input logic [31:0] l, input logic [63:0] d,
                               input logic [3:0] n, input logic opens, input logic ends);
        chunk_item_t c;
        c.seed = s;
        c.length = l;
        c.data = d;
        c.nbytes = n;
        c.opens = opens;
        c.ends = ends;
        if ((queued_total / 150) % 4 == 2)
        begin
            c.gap = 0;
        end
        else
        begin
            c.gap = $urandom_range(0, 12);
        end
        pending_chunks.push_back(c);
        queued_total++;
    endtask

    task automatic queue_message(input bit fresh);
        int unsigned full_lanes;
        int unsigned tail_bytes;
        int unsigned idx;
        msg_end_t    ending;
        logic [31:0] span;
        full_lanes = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 5);
        ending = msg_end_t'($urandom_range(0, 2));
        tail_bytes = $urandom_range(1, 7);
        span = 32'(full_lanes * 8);
        if (ending == END_TAIL)
        begin
            span = span + 32'(tail_bytes);
        end
        else if (ending == END_LAST)
        begin
            span = span + 32'd8;
        end
        if ($urandom_range(0, 1) == 0)
        begin
            span = $urandom;
        end
        for (idx = 0; idx < full_lanes; idx++)
        begin
            queue_chunk(random64(), (idx == 0) ? span : $urandom, random64(), full_count_code(),
                        fresh && (idx == 0), 1'b0);
        end
        case (ending)
            END_TAIL:  queue_chunk(random64(), span, random64(), 4'(tail_bytes),
                                   fresh && (full_lanes == 0), 1'($urandom_range(0, 1)));
            END_EMPTY: queue_chunk(random64(), span, random64(), 4'd0,
                                   fresh && (full_lanes == 0), 1'($urandom_range(0, 1)));
            default:   queue_chunk(random64(), span, random64(), full_count_code(),
                                   fresh && (full_lanes == 0), 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            hold_off <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (absorb_chunk(on_bus, fresh_digest))
                begin
                    expected_hashes.push_back(fresh_digest);
                end
            end
            if (!in_valid || in_ready)
            begin
                if (hold_off != 0)
                begin
                    hold_off <= hold_off - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_chunks.size() != 0)
                begin
                    on_bus = pending_chunks.pop_front();
                    seed <= on_bus.seed;
                    message_length <= on_bus.length;
                    chunk_data <= on_bus.data;
                    chunk_bytes <= on_bus.nbytes;
                    first_chunk <= on_bus.opens;
                    last_chunk <= on_bus.ends;
                    in_valid <= 1'b1;
                    hold_off <= on_bus.gap;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                hashes_seen++;
                if (expected_hashes.size() == 0)
                begin
                    report_mismatch($sformatf("hash %h with none expected", hash_value));
                end
                else
                begin
                    wanted_hash = expected_hashes.pop_front();
                    if (hash_value !== wanted_hash)
                    begin
                        report_mismatch($sformatf("hash_value %h, expected %h",
                                                  hash_value, wanted_hash));
                    end
                end
                stall_draw = ((hashes_seen / 60) % 3 == 1) ? 0 : $urandom_range(0, 12);
                stall_left <= stall_draw;
                out_ready <= (stall_draw == 0);
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_ready <= (stall_left == 1);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned pick;

        // A chunk arriving with no message open after reset, then a tail that closes it.
        queue_chunk(random64(), $urandom, random64(), FULL_LANE, 1'b0, 1'b0);
        queue_chunk(random64(), $urandom, random64(), 4'd3, 1'b0, 1'b0);
        queue_chunk(64'd0, 32'd0, 64'd0, 4'd0, 1'b1, 1'b0);
        queue_chunk('1, '1, '1, FULL_LANE, 1'b1, 1'b1);
        queue_chunk(64'd0, '1, 64'd0, FULL_LANE, 1'b1, 1'b0);
        queue_chunk('1, 32'd0, '1, 4'd15, 1'b0, 1'b0);
        queue_chunk(random64(), $urandom, '1, 4'd9, 1'b0, 1'b0);
        queue_chunk(random64(), $urandom, '1, 4'd7, 1'b0, 1'b0);
        for (n = 1; n <= 7; n++)
        begin
            queue_chunk(random64(), $urandom, '1, 4'(n), 1'b1, 1'b0);
        end
        for (n = 10; n <= 14; n++)
        begin
            queue_chunk(random64(), $urandom, random64(), 4'(n), (n == 10), (n == 14));
        end
        // A chunk with no message open, left by the previous message, and a restart mid-message.
        queue_chunk(random64(), $urandom, random64(), FULL_LANE, 1'b0, 1'b1);
        queue_chunk(random64(), $urandom, random64(), FULL_LANE, 1'b1, 1'b0);
        queue_chunk(random64(), $urandom, random64(), FULL_LANE, 1'b1, 1'b0);
        queue_chunk(random64(), $urandom, random64(), 4'd5, 1'b0, 1'b1);

        while (queued_total < STIMULUS_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                queue_message(1'b1);
            end
            else if (pick < 90)
            begin
                queue_message(1'b0);
            end
            else
            begin
                queue_chunk(random64(), $urandom, random64(), 4'($urandom_range(0, 15)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
        queue_chunk(random64(), $urandom, random64(), 4'd0, 1'b0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_chunks.size() != 0 || in_valid)
        begin
            @(posedge clk);
        end
        while (expected_hashes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== seeded_hash64_stream.f =====
+incdir+hdl
hdl/sh64_pkg.sv
hdl/sh64_mul.sv
hdl/sh64_queue.sv
hdl/sh64_front.sv
hdl/sh64_back.sv
hdl/seeded_hash64_stream.sv
hdl/sh64_checker.sv
verif/testbench.sv
